/* hdl/tel_pkg.sv */
// ----------------------------------------------------------------------------
// tel_pkg
// Shared types, character codes and echo sequence tables for the terminal
// echo line editor.
// ----------------------------------------------------------------------------
package tel_pkg;

    localparam logic OP_RX   = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_FS    = 8'd28;
    localparam logic [7:0] CH_SP    = 8'd32;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_AT    = 8'd64;
    localparam logic [7:0] CH_BSL   = 8'd92;
    localparam logic [7:0] CH_CARET = 8'd94;
    localparam logic [7:0] CH_DEL   = 8'd127;

    localparam logic [1:0] KIND_ECHO   = 2'd0;
    localparam logic [1:0] KIND_READ   = 2'd1;
    localparam logic [1:0] KIND_NOLINE = 2'd2;

    typedef logic [2:0] t_jtype;

    localparam t_jtype J_READ        = 3'd0;
    localparam t_jtype J_NOLINE      = 3'd1;
    localparam t_jtype J_ERASE_CTRL  = 3'd2;
    localparam t_jtype J_ERASE_PLAIN = 3'd3;
    localparam t_jtype J_ECHO_LF     = 3'd4;
    localparam t_jtype J_ECHO_CARET  = 3'd5;
    localparam t_jtype J_ECHO_PLAIN  = 3'd6;

    typedef logic [2:0] t_step;

    typedef struct packed {
        t_jtype     jtype;
        logic [7:0] jbyte;
        logic       line_ready;
    } t_job;

    localparam int JQ_DEPTH = 4;
    localparam int JQ_AW    = 2;

    function automatic t_step tel_len(input t_jtype jt);
        t_step len;
        unique case (jt)
            J_ERASE_CTRL:  len = 3'd6;
            J_ERASE_PLAIN: len = 3'd3;
            J_ECHO_LF:     len = 3'd2;
            J_ECHO_CARET:  len = 3'd2;
            default:       len = 3'd1;
        endcase
        return len;
    endfunction

    function automatic logic [1:0] tel_kind(input t_jtype jt);
        logic [1:0] k;
        unique case (jt)
            J_READ:   k = KIND_READ;
            J_NOLINE: k = KIND_NOLINE;
            default:  k = KIND_ECHO;
        endcase
        return k;
    endfunction

    function automatic logic [7:0] tel_word(input t_jtype jt, input logic [7:0] b,
                                            input t_step step);
        logic [7:0] w;
        unique case (jt)
            J_READ:        w = b;
            J_NOLINE:      w = CH_NUL;
            J_ERASE_CTRL:  w = (step == 3'd2 || step == 3'd3) ? CH_SP : CH_BS;
            J_ERASE_PLAIN: w = (step == 3'd1) ? CH_SP : CH_BS;
            J_ECHO_LF:     w = (step == 3'd0) ? CH_CR : CH_LF;
            J_ECHO_CARET:  w = (step == 3'd0) ? CH_CARET : b;
            J_ECHO_PLAIN:  w = b;
            default:       w = CH_NUL;
        endcase
        return w;
    endfunction

endpackage

/* hdl/tel_front.sv */
// ----------------------------------------------------------------------------
// tel_front
// Accepts input words, owns the line buffer and its counters, and turns each
// word into at most one echo or read job for the back end.
// ----------------------------------------------------------------------------
module tel_front #(
    parameter int BUFFER_DEPTH = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_full,
    input  logic             i_op,
    input  logic [7:0]       i_rx_byte,
    input  logic             i_cfg_valid,
    input  logic             i_cfg_echo_enable,
    input  logic             i_q_full,
    output logic             o_job_push,
    output tel_pkg::t_job    o_job
);

    localparam int IW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(BUFFER_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(BUFFER_DEPTH);

    logic [7:0]    r_mem [BUFFER_DEPTH];
    logic [7:0]    r_rd_data;
    logic          r_echo;
    logic          r_s2_valid;
    logic          r_s2_op;
    logic [7:0]    r_s2_byte;
    logic [IW-1:0] r_head, n_head;
    logic [IW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_fill, n_fill;
    logic [CW-1:0] r_nl, n_nl;

    logic          acc;
    logic [IW-1:0] head_next;
    logic [IW-1:0] tail_next;
    logic [IW-1:0] tail_prev;
    logic [IW-1:0] rd_addr;
    logic [7:0]    map_byte;
    logic          do_store;
    logic          wr_en;
    logic          push;
    tel_pkg::t_job job;

    assign o_full    = r_s2_valid | i_q_full;
    assign acc       = i_push & ~o_full;
    assign head_next = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
    assign tail_next = (r_tail == LAST_IDX) ? '0 : r_tail + 1'b1;
    assign tail_prev = (r_tail == '0) ? LAST_IDX : r_tail - 1'b1;
    assign rd_addr   = (i_op == tel_pkg::OP_READ) ? r_head : tail_prev;
    assign map_byte  = (i_rx_byte == tel_pkg::CH_CR) ? tel_pkg::CH_LF : i_rx_byte;

    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_fill   = r_fill;
        n_nl     = r_nl;
        do_store = 1'b0;
        wr_en    = 1'b0;
        push     = 1'b0;
        job.jtype      = tel_pkg::J_ECHO_PLAIN;
        job.jbyte      = r_s2_byte;
        job.line_ready = 1'b0;
        if (r_s2_valid) begin
            if (r_s2_op == tel_pkg::OP_READ) begin
                push = 1'b1;
                if (r_nl != '0 && r_fill != '0) begin
                    n_head    = head_next;
                    n_fill    = r_fill - 1'b1;
                    if (r_rd_data == tel_pkg::CH_LF) begin
                        n_nl = r_nl - 1'b1;
                    end
                    job.jtype = tel_pkg::J_READ;
                    job.jbyte = r_rd_data;
                end else begin
                    job.jtype = tel_pkg::J_NOLINE;
                    job.jbyte = tel_pkg::CH_NUL;
                end
            end else if (!r_echo) begin
                do_store = 1'b1;
            end else if (r_s2_byte == tel_pkg::CH_BS || r_s2_byte == tel_pkg::CH_DEL) begin
                if (r_fill != '0 && r_rd_data != tel_pkg::CH_LF) begin
                    push      = 1'b1;
                    n_tail    = tail_prev;
                    n_fill    = r_fill - 1'b1;
                    job.jtype = (r_rd_data < tel_pkg::CH_SP) ? tel_pkg::J_ERASE_CTRL
                                                             : tel_pkg::J_ERASE_PLAIN;
                end
            end else begin
                push     = 1'b1;
                do_store = 1'b1;
                if (r_s2_byte == tel_pkg::CH_LF) begin
                    job.jtype = tel_pkg::J_ECHO_LF;
                end else if (r_s2_byte == tel_pkg::CH_NUL) begin
                    job.jtype = tel_pkg::J_ECHO_CARET;
                    job.jbyte = tel_pkg::CH_ZERO;
                end else if (r_s2_byte == tel_pkg::CH_FS) begin
                    job.jtype = tel_pkg::J_ECHO_CARET;
                    job.jbyte = tel_pkg::CH_BSL;
                end else if (r_s2_byte < tel_pkg::CH_SP) begin
                    job.jtype = tel_pkg::J_ECHO_CARET;
                    job.jbyte = r_s2_byte + tel_pkg::CH_AT;
                end
            end
            if (do_store && r_fill < FULL_CNT) begin
                wr_en  = 1'b1;
                n_tail = tail_next;
                n_fill = r_fill + 1'b1;
                if (r_s2_byte == tel_pkg::CH_LF) begin
                    n_nl = r_nl + 1'b1;
                end
            end
        end
        job.line_ready = (n_nl != '0);
    end

    assign o_job_push = push;
    assign o_job      = job;

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_rd_data <= r_mem[rd_addr];
        end
        if (wr_en) begin
            r_mem[r_tail] <= r_s2_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s2_op   <= i_op;
            r_s2_byte <= map_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_echo     <= 1'b1;
            r_s2_valid <= 1'b0;
            r_head     <= '0;
            r_tail     <= '0;
            r_fill     <= '0;
            r_nl       <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_echo <= i_cfg_echo_enable;
            end
            r_s2_valid <= acc;
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_fill     <= n_fill;
            r_nl       <= n_nl;
        end
    end

endmodule

/* hdl/tel_jobq.sv */
// ----------------------------------------------------------------------------
// tel_jobq
// Short job queue between the front end and the echo sequencer.
// ----------------------------------------------------------------------------
module tel_jobq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tel_pkg::t_job i_job,
    output logic          o_full,
    output logic          o_valid,
    output tel_pkg::t_job o_job,
    input  logic          i_pop
);

    tel_pkg::t_job            r_q [tel_pkg::JQ_DEPTH];
    logic [tel_pkg::JQ_AW-1:0] r_wp;
    logic [tel_pkg::JQ_AW-1:0] r_rp;
    logic [tel_pkg::JQ_AW:0]   r_cnt;
    logic                      do_push;
    logic                      do_pop;

    assign o_full  = (r_cnt == (tel_pkg::JQ_AW + 1)'(tel_pkg::JQ_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_q[r_rp];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

/* hdl/tel_back.sv */
// ----------------------------------------------------------------------------
// tel_back
// Expands each job into its result words, one per cycle into an output
// register while that register is empty or being popped.
// ----------------------------------------------------------------------------
module tel_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    input  tel_pkg::t_job i_job,
    output logic          o_job_pop,
    output logic          o_empty,
    input  logic          i_pop,
    output logic [1:0]    o_kind,
    output logic [7:0]    o_data_byte,
    output logic          o_last,
    output logic          o_line_ready
);

    tel_pkg::t_step r_step;
    logic           r_out_valid;
    logic [1:0]     r_kind;
    logic [7:0]     r_data;
    logic           r_last;
    logic           r_line_ready;
    logic           advance;
    logic           word_last;

    assign advance   = i_job_valid & (~r_out_valid | i_pop);
    assign word_last = (r_step == tel_pkg::tel_len(i_job.jtype) - 3'd1);
    assign o_job_pop = advance & word_last;

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_kind       <= tel_pkg::tel_kind(i_job.jtype);
            r_data       <= tel_pkg::tel_word(i_job.jtype, i_job.jbyte, r_step);
            r_last       <= word_last;
            r_line_ready <= i_job.line_ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_step      <= '0;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                r_step      <= word_last ? '0 : r_step + 3'd1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_empty      = ~r_out_valid;
    assign o_kind       = r_kind;
    assign o_data_byte  = r_data;
    assign o_last       = r_last;
    assign o_line_ready = r_line_ready;

endmodule

/* hdl/terminal_echo_line_editor.sv */
// ----------------------------------------------------------------------------
// terminal_echo_line_editor
// Terminal line editor: buffers received bytes, echoes and erases on screen,
// hands out buffered bytes once a full line is held.
// ----------------------------------------------------------------------------
//  channel  | handshake               | payload
//  ---------+-------------------------+-------------------------------------
//  input    | i_push / o_full         | i_op, i_rx_byte
//  result   | o_empty / i_pop         | o_kind, o_data_byte, o_last,
//           |                         | o_line_ready
//  config   | i_cfg_valid/o_cfg_ready | i_cfg_echo_enable
//
//  The front end takes a new input word only once the previous one has used
//  the line buffer read port and updated the buffer and counters.
//  The back end sends one result word per cycle while results are popped, zero to six per input word.
//  A four-entry job queue lets each side stall on its own.
//  Synchronous active-low reset clears counters and queues; no clearing pass.
// ----------------------------------------------------------------------------
module terminal_echo_line_editor #(
    parameter int BUFFER_DEPTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    output logic       o_full,
    input  logic       i_op,
    input  logic [7:0] i_rx_byte,
    output logic       o_empty,
    input  logic       i_pop,
    output logic [1:0] o_kind,
    output logic [7:0] o_data_byte,
    output logic       o_last,
    output logic       o_line_ready,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_echo_enable
);

    logic          job_push;
    tel_pkg::t_job job_in;
    logic          q_full;
    logic          q_valid;
    tel_pkg::t_job q_job;
    logic          q_pop;

    assign o_cfg_ready = 1'b1;

    tel_front #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_push            (i_push),
        .o_full            (o_full),
        .i_op              (i_op),
        .i_rx_byte         (i_rx_byte),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_echo_enable (i_cfg_echo_enable),
        .i_q_full          (q_full),
        .o_job_push        (job_push),
        .o_job             (job_in)
    );

    tel_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (q_job),
        .i_pop   (q_pop)
    );

    tel_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (q_valid),
        .i_job        (q_job),
        .o_job_pop    (q_pop),
        .o_empty      (o_empty),
        .i_pop        (i_pop),
        .o_kind       (o_kind),
        .o_data_byte  (o_data_byte),
        .o_last       (o_last),
        .o_line_ready (o_line_ready)
    );

endmodule

/* hdl/tel_checker.sv */
// ----------------------------------------------------------------------------
// tel_port_checker
// Port-level checks on the result channel of the terminal echo line editor.
// ----------------------------------------------------------------------------
module tel_port_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_empty,
    input logic       i_pop,
    input logic [1:0] i_kind,
    input logic [7:0] i_data_byte,
    input logic       i_last,
    input logic       i_line_ready
);

    // Read data and no-line replies are single words.
    a_single_word : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_empty && i_kind != tel_pkg::KIND_ECHO) |-> i_last)
    else $error("read or no-line word without last");

    // No-line reply carries zero data and no line ready.
    a_noline : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_empty && i_kind == tel_pkg::KIND_NOLINE) |->
            (i_data_byte == tel_pkg::CH_NUL && !i_line_ready))
    else $error("bad no-line reply");

    // Words of one input share line ready.
    a_line_ready_group : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_empty && i_pop && !i_last) |=> (i_empty || i_line_ready == $past(i_line_ready)))
    else $error("line ready changed within one input");

    // Hold a stalled result.
    a_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_empty && !i_pop) |=>
            (!i_empty && $stable(i_data_byte) && $stable(i_kind) && $stable(i_last)))
    else $error("stalled result changed");

endmodule

bind terminal_echo_line_editor tel_port_checker u_tel_port_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_empty      (o_empty),
    .i_pop        (i_pop),
    .i_kind       (o_kind),
    .i_data_byte  (o_data_byte),
    .i_last       (o_last),
    .i_line_ready (o_line_ready)
);

/* sim/tel_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tel_checker
// Watches the input, result and config channels of the terminal echo line
// editor, keeps its own copy of the line buffer and echo mode, and compares
// every popped result word field by field with the oldest predicted word.
// ----------------------------------------------------------------------------
module tel_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic       i_full,
    input  logic       i_op,
    input  logic [7:0] i_rx_byte,
    input  logic       i_empty,
    input  logic       i_pop,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_data_byte,
    input  logic       i_last,
    input  logic       i_line_ready,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic       i_cfg_echo_enable,
    output int         o_pending,
    output int         o_fail_count
);

    localparam int LINE_DEPTH = 64;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
        logic       line_ready;
    } t_tx_word;

    t_tx_word   tx_due[$];
    t_tx_word   step_words[$];
    logic [7:0] line_mem [LINE_DEPTH];
    logic [5:0] head_ix;
    logic [5:0] tail_ix;
    logic [6:0] fill_cnt;
    logic [6:0] lf_cnt;
    logic       echo_on;

    function automatic logic [5:0] ix_next(input logic [5:0] ix);
        return (ix == LINE_DEPTH - 1) ? 6'd0 : ix + 6'd1;
    endfunction

    function automatic logic [5:0] ix_prev(input logic [5:0] ix);
        return (ix == 6'd0) ? 6'(LINE_DEPTH - 1) : ix - 6'd1;
    endfunction

    task automatic report_mismatch(input string what);
        o_fail_count++;
        $display("%0t mismatch: %s", $time, what);
    endtask

    task automatic add_word(input logic [1:0] kind, input logic [7:0] data);
        step_words.push_back('{kind, data, 1'b0, 1'b0});
    endtask

    task automatic buffer_char(input logic [7:0] ch);
        if (fill_cnt < LINE_DEPTH) begin
            line_mem[tail_ix] = ch;
            tail_ix = ix_next(tail_ix);
            fill_cnt++;
            if (ch == tel_pkg::CH_LF) begin
                lf_cnt++;
            end
        end
    endtask

    task automatic edit_line(input logic op, input logic [7:0] rx);
        logic [7:0] ch;
        logic [7:0] held;
        logic [5:0] prev;
        step_words.delete();
        if (op == tel_pkg::OP_READ) begin
            if (lf_cnt != 0 && fill_cnt != 0) begin
                held = line_mem[head_ix];
                head_ix = ix_next(head_ix);
                fill_cnt--;
                if (held == tel_pkg::CH_LF) begin
                    lf_cnt--;
                end
                add_word(tel_pkg::KIND_READ, held);
            end else begin
                add_word(tel_pkg::KIND_NOLINE, tel_pkg::CH_NUL);
            end
        end else begin
            ch = (rx == tel_pkg::CH_CR) ? tel_pkg::CH_LF : rx;
            if (!echo_on) begin
                buffer_char(ch);
            end else if (ch == tel_pkg::CH_BS || ch == tel_pkg::CH_DEL) begin
                if (fill_cnt != 0) begin
                    prev = ix_prev(tail_ix);
                    held = line_mem[prev];
                    if (held != tel_pkg::CH_LF) begin
                        tail_ix = prev;
                        fill_cnt--;
                        if (held < tel_pkg::CH_SP) begin
                            add_word(tel_pkg::KIND_ECHO, tel_pkg::CH_BS);
                            add_word(tel_pkg::KIND_ECHO, tel_pkg::CH_BS);
                            add_word(tel_pkg::KIND_ECHO, tel_pkg::CH_SP);
                            add_word(tel_pkg::KIND_ECHO, tel_pkg::CH_SP);
                            add_word(tel_pkg::KIND_ECHO, tel_pkg::CH_BS);
                            add_word(tel_pkg::KIND_ECHO, tel_pkg::CH_BS);
                        end else begin
                            add_word(tel_pkg::KIND_ECHO, tel_pkg::CH_BS);
                            add_word(tel_pkg::KIND_ECHO, tel_pkg::CH_SP);
                            add_word(tel_pkg::KIND_ECHO, tel_pkg::CH_BS);
                        end
                    end
                end
            end else begin
                if (ch == tel_pkg::CH_LF) begin
                    add_word(tel_pkg::KIND_ECHO, tel_pkg::CH_CR);
                    add_word(tel_pkg::KIND_ECHO, tel_pkg::CH_LF);
                end else if (ch == tel_pkg::CH_NUL) begin
                    add_word(tel_pkg::KIND_ECHO, tel_pkg::CH_CARET);
                    add_word(tel_pkg::KIND_ECHO, tel_pkg::CH_ZERO);
                end else if (ch == tel_pkg::CH_FS) begin
                    add_word(tel_pkg::KIND_ECHO, tel_pkg::CH_CARET);
                    add_word(tel_pkg::KIND_ECHO, tel_pkg::CH_BSL);
                end else if (ch < tel_pkg::CH_SP) begin
                    add_word(tel_pkg::KIND_ECHO, tel_pkg::CH_CARET);
                    add_word(tel_pkg::KIND_ECHO, tel_pkg::CH_AT + ch);
                end else begin
                    add_word(tel_pkg::KIND_ECHO, ch);
                end
                buffer_char(ch);
            end
        end
        foreach (step_words[k]) begin
            step_words[k].line_ready = (lf_cnt != 0);
            step_words[k].last       = (k == step_words.size() - 1);
            tx_due.push_back(step_words[k]);
        end
    endtask

    task automatic check_word();
        t_tx_word want;
        if (tx_due.size() == 0) begin
            report_mismatch($sformatf("unexpected word kind %0d data %02h",
                                      i_kind, i_data_byte));
        end else begin
            want = tx_due.pop_front();
            if (i_kind !== want.kind) begin
                report_mismatch($sformatf("kind %0d, want %0d", i_kind, want.kind));
            end
            if (i_data_byte !== want.data) begin
                report_mismatch($sformatf("data_byte %02h, want %02h",
                                          i_data_byte, want.data));
            end
            if (i_last !== want.last) begin
                report_mismatch($sformatf("last %b, want %b", i_last, want.last));
            end
            if (i_line_ready !== want.line_ready) begin
                report_mismatch($sformatf("line_ready %b, want %b",
                                          i_line_ready, want.line_ready));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tx_due.delete();
            foreach (line_mem[k]) begin
                line_mem[k] = 8'd0;
            end
            head_ix  = '0;
            tail_ix  = '0;
            fill_cnt = '0;
            lf_cnt   = '0;
            echo_on  = 1'b1;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                echo_on = i_cfg_echo_enable;
            end
            if (i_pop && !i_empty) begin
                check_word();
            end
            if (i_push && !i_full) begin
                edit_line(i_op, i_rx_byte);
            end
        end
        o_pending = tx_due.size();
    end

endmodule

/* sim/tb_terminal_echo_line_editor.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_terminal_echo_line_editor
// Drives the terminal echo line editor with directed edge cases and random
// typed lines under both echo modes and several stall patterns; a checker
// beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_terminal_echo_line_editor;

    localparam int SETTLE_CYCLES = 32;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_push;
    logic       o_full;
    logic       i_op;
    logic [7:0] i_rx_byte;
    logic       o_empty;
    logic       i_pop;
    logic [1:0] o_kind;
    logic [7:0] o_data_byte;
    logic       o_last;
    logic       o_line_ready;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic       i_cfg_echo_enable;
    int         pending;
    int         fail_count;
    int         send_idle;
    int         recv_idle;

    terminal_echo_line_editor u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_push            (i_push),
        .o_full            (o_full),
        .i_op              (i_op),
        .i_rx_byte         (i_rx_byte),
        .o_empty           (o_empty),
        .i_pop             (i_pop),
        .o_kind            (o_kind),
        .o_data_byte       (o_data_byte),
        .o_last            (o_last),
        .o_line_ready      (o_line_ready),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_echo_enable (i_cfg_echo_enable)
    );

    tel_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_push            (i_push),
        .i_full            (o_full),
        .i_op              (i_op),
        .i_rx_byte         (i_rx_byte),
        .i_empty           (o_empty),
        .i_pop             (i_pop),
        .i_kind            (o_kind),
        .i_data_byte       (o_data_byte),
        .i_last            (o_last),
        .i_line_ready      (o_line_ready),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_echo_enable (i_cfg_echo_enable),
        .o_pending         (pending),
        .o_fail_count      (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("[terminal_echo_line_editor] ERROR");
        $finish;
    end

    always @(negedge i_clk) begin
        i_pop <= ($urandom_range(0, 99) >= recv_idle);
    end

    task automatic put_word(input logic op, input logic [7:0] b);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle) begin
            i_push <= 1'b0;
            @(negedge i_clk);
        end
        i_push    <= 1'b1;
        i_op      <= op;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (o_full) begin
            @(posedge i_clk);
        end
    endtask

    // hold the sender until every predicted word has been popped
    task automatic drain_results();
        @(negedge i_clk);
        i_push <= 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_echo(input logic en);
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_valid       <= 1'b1;
        i_cfg_echo_enable <= en;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 8'($urandom_range(32, 126));
        end else if (r < 75) begin
            return 8'($urandom_range(0, 31));
        end else if (r < 88) begin
            return $urandom_range(0, 1) ? tel_pkg::CH_BS : tel_pkg::CH_DEL;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // one typed line with edits, usually its terminator, and some reads; sometimes noise
    task automatic feed_line(output int n_fed);
        int len;
        int n_reads;
        n_fed = 0;
        if ($urandom_range(0, 9) == 0) begin
            put_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            n_fed = 1;
        end else begin
            len = $urandom_range(0, 10);
            for (int k = 0; k < len; k++) begin
                put_word(tel_pkg::OP_RX, pick_char());
            end
            n_fed = len;
            if ($urandom_range(0, 7) != 0) begin
                put_word(tel_pkg::OP_RX,
                         $urandom_range(0, 1) ? tel_pkg::CH_CR : tel_pkg::CH_LF);
                n_fed++;
            end
            n_reads = $urandom_range(0, len + 3);
            for (int k = 0; k < n_reads; k++) begin
                put_word(tel_pkg::OP_READ, 8'($urandom_range(0, 255)));
            end
            n_fed += n_reads;
        end
        if ($urandom_range(0, 24) == 0) begin
            drain_results();
        end
    endtask

    task automatic run_lines(input int n_items);
        int n_done;
        int n_fed;
        n_done = 0;
        while (n_done < n_items) begin
            feed_line(n_fed);
            n_done += n_fed;
        end
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_push            = 1'b0;
        i_op              = tel_pkg::OP_RX;
        i_rx_byte         = 8'd0;
        i_cfg_valid       = 1'b0;
        i_cfg_echo_enable = 1'b0;
        send_idle         = 36;
        recv_idle         = 81;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // echo on after reset: empty reads and erases, caret forms, erase kinds
        put_word(tel_pkg::OP_READ, 8'hFF);
        put_word(tel_pkg::OP_RX, tel_pkg::CH_BS);
        put_word(tel_pkg::OP_RX, tel_pkg::CH_NUL);
        put_word(tel_pkg::OP_RX, tel_pkg::CH_FS);
        put_word(tel_pkg::OP_RX, 8'd1);
        put_word(tel_pkg::OP_RX, 8'd31);
        put_word(tel_pkg::OP_RX, 8'hFF);
        put_word(tel_pkg::OP_RX, 8'h61);
        put_word(tel_pkg::OP_READ, 8'h00);
        put_word(tel_pkg::OP_RX, tel_pkg::CH_DEL);
        put_word(tel_pkg::OP_RX, tel_pkg::CH_BS);
        put_word(tel_pkg::OP_RX, tel_pkg::CH_BS);
        put_word(tel_pkg::OP_RX, tel_pkg::CH_CR);
        put_word(tel_pkg::OP_RX, tel_pkg::CH_BS);
        put_word(tel_pkg::OP_READ, 8'h00);
        put_word(tel_pkg::OP_READ, 8'h00);
        put_word(tel_pkg::OP_READ, 8'h00);
        put_word(tel_pkg::OP_READ, 8'h00);
        put_word(tel_pkg::OP_READ, 8'h00);

        // echo off: edit codes are buffered as plain bytes
        write_echo(1'b0);
        put_word(tel_pkg::OP_RX, tel_pkg::CH_BS);
        put_word(tel_pkg::OP_RX, tel_pkg::CH_DEL);
        put_word(tel_pkg::OP_RX, tel_pkg::CH_CR);
        put_word(tel_pkg::OP_READ, 8'h00);
        put_word(tel_pkg::OP_READ, 8'h00);
        put_word(tel_pkg::OP_READ, 8'h00);
        put_word(tel_pkg::OP_READ, 8'h00);

        run_lines(20);
        write_echo(1'b1);
        run_lines(25);

        send_idle = 81;
        recv_idle = 36;
        write_echo(1'b0);
        run_lines(15);
        write_echo(1'b1);
        run_lines(25);

        send_idle = 0;
        recv_idle = 0;
        // overfill the buffer with echo on, then close the line
        for (int k = 0; k < 66; k++) begin
            put_word(tel_pkg::OP_RX, 8'($urandom_range(32, 126)));
        end
        put_word(tel_pkg::OP_RX, tel_pkg::CH_BS);
        put_word(tel_pkg::OP_RX, tel_pkg::CH_CR);
        run_lines(20);
        write_echo(1'b0);
        run_lines(10);
        write_echo(1'b1);
        run_lines(10);

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("[terminal_echo_line_editor] OK");
        end else begin
            $display("[terminal_echo_line_editor] ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
hdl/tel_pkg.sv
hdl/tel_front.sv
hdl/tel_jobq.sv
hdl/tel_back.sv
hdl/terminal_echo_line_editor.sv
hdl/tel_checker.sv
sim/tel_checker.sv
sim/tb_terminal_echo_line_editor.sv
